// File: rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants of the triggered sample capture block.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int TSC_MAX_CHANNELS = 8;
  localparam int TSC_SAMPLE_W     = 32;
  localparam int TSC_ADDR_W       = 8;
  localparam int TSC_CFG_DATA_W   = 64;
  localparam int TSC_CFG_ADDR_W   = 6;

  // Compare modes
  localparam logic [3:0] CMP_UGT    = 4'd0;
  localparam logic [3:0] CMP_ULT    = 4'd1;
  localparam logic [3:0] CMP_SGT    = 4'd2;
  localparam logic [3:0] CMP_SLT    = 4'd3;
  localparam logic [3:0] CMP_EQ     = 4'd4;
  localparam logic [3:0] CMP_NE     = 4'd5;
  localparam logic [3:0] CMP_ALWAYS = 4'd6;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_COMPARE_MODE   = 3'd0;
  localparam logic [2:0] REG_TRIGGER_SELECT = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT  = 3'd2;
  localparam logic [2:0] REG_CONTINUOUS     = 3'd3;
  localparam logic [2:0] REG_SAMPLE_TOTAL   = 3'd4;
  localparam logic [2:0] REG_THRESHOLD      = 3'd5;
  localparam logic [2:0] REG_ADDR_TABLE     = 3'd6;

  // Request opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_CONTROL = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  control_flags;
    logic [31:0] sample_0;
    logic [31:0] sample_1;
    logic [31:0] sample_2;
    logic [31:0] sample_3;
    logic [31:0] sample_4;
    logic [31:0] sample_5;
    logic [31:0] sample_6;
    logic [31:0] sample_7;
  } tsc_in_t;

  typedef struct packed {
    logic        has_sample;
    logic [2:0]  channel_index;
    logic [7:0]  register_address;
    logic [31:0] sample_value;
    logic        last;
    logic        armed_flag;
    logic        active_flag;
    logic        done_flag;
  } tsc_out_t;

  typedef struct packed {
    logic done;
    logic active;
    logic armed;
  } tsc_flags_t;

endpackage

// File: rtl/triggered_sample_capture.sv
// ----------------------------------------------------------------------------
// triggered_sample_capture
// Triggered multi-channel capture controller with APB configuration.
// ----------------------------------------------------------------------------
// Each request is either a sample tick (up to eight 32-bit channel samples)
// or a control write that loads the armed/active/done flags. Trigger test,
// flag update and tick counting are done in the cycle a request is accepted;
// the result set then sits in a one-deep staging register and is handed to
// the output stage, which plays it out one result per cycle unless out_stall
// holds it. A capturing tick gives min(channel_count, CHAN_LIMIT) results
// (channel 0 upwards, last on the final one); every other request gives a
// single status result. The output stage therefore sets the rate, and
// requests are taken back to back whenever the staging register is free or
// drains into the output stage in the same cycle.
// Configuration registers sit at byte address 8*i on a 64-bit APB port and
// must only be written while the block is idle.
// ----------------------------------------------------------------------------
module triggered_sample_capture #(
  parameter int CHAN_LIMIT = tsc_pkg::TSC_MAX_CHANNELS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  tsc_pkg::tsc_in_t                     in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output tsc_pkg::tsc_out_t                    out_data,
  // configuration
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [tsc_pkg::TSC_CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [tsc_pkg::TSC_CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [tsc_pkg::TSC_CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);
  import tsc_pkg::*;

  localparam int IDX_W = (CHAN_LIMIT > 1) ? $clog2(CHAN_LIMIT) : 1;
  localparam int CNT_W = $clog2(CHAN_LIMIT + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [3:0]  cmp_mode_r;
  logic [2:0]  trig_sel_r;
  logic [3:0]  chan_cnt_r;
  logic        cont_r;
  logic [31:0] total_r;
  logic [31:0] thresh_r;
  logic [63:0] addr_tbl_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_mode_r <= '0;
      trig_sel_r <= '0;
      chan_cnt_r <= '0;
      cont_r     <= 1'b0;
      total_r    <= '0;
      thresh_r   <= '0;
      addr_tbl_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COMPARE_MODE:   cmp_mode_r <= cfg_pwdata[3:0];
        REG_TRIGGER_SELECT: trig_sel_r <= cfg_pwdata[2:0];
        REG_CHANNEL_COUNT:  chan_cnt_r <= cfg_pwdata[3:0];
        REG_CONTINUOUS:     cont_r     <= cfg_pwdata[0];
        REG_SAMPLE_TOTAL:   total_r    <= cfg_pwdata[31:0];
        REG_THRESHOLD:      thresh_r   <= cfg_pwdata[31:0];
        REG_ADDR_TABLE:     addr_tbl_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COMPARE_MODE:   cfg_prdata = {60'd0, cmp_mode_r};
      REG_TRIGGER_SELECT: cfg_prdata = {61'd0, trig_sel_r};
      REG_CHANNEL_COUNT:  cfg_prdata = {60'd0, chan_cnt_r};
      REG_CONTINUOUS:     cfg_prdata = {63'd0, cont_r};
      REG_SAMPLE_TOTAL:   cfg_prdata = {32'd0, total_r};
      REG_THRESHOLD:      cfg_prdata = {32'd0, thresh_r};
      REG_ADDR_TABLE:     cfg_prdata = addr_tbl_r;
      default:            cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Capture state
  // --------------------------------------------------------------------------
  tsc_flags_t  flags_r, flags_nxt;
  logic [31:0] tick_r, tick_nxt;

  // staging register: result set of the last accepted request
  logic                    stg_valid_r, stg_valid_nxt;
  logic                    stg_cap_r, stg_cap_nxt;
  logic [CNT_W-1:0]        stg_n_r, stg_n_nxt;
  tsc_flags_t              stg_flags_r;
  logic [31:0]             stg_smp_r [CHAN_LIMIT];

  // output stage: result set being played out
  logic                    emt_valid_r, emt_valid_nxt;
  logic                    emt_cap_r;
  logic [CNT_W-1:0]        emt_n_r;
  tsc_flags_t              emt_flags_r;
  logic [31:0]             emt_smp_r [CHAN_LIMIT];
  logic [IDX_W-1:0]        beat_r, beat_nxt;

  logic        in_acc, emt_last, emt_done, emt_load;
  logic [31:0] in_smp [TSC_MAX_CHANNELS];
  logic [31:0] trig_smp;
  logic        hit;
  logic [CNT_W-1:0] n_sat;

  assign in_smp[0] = in_data.sample_0;
  assign in_smp[1] = in_data.sample_1;
  assign in_smp[2] = in_data.sample_2;
  assign in_smp[3] = in_data.sample_3;
  assign in_smp[4] = in_data.sample_4;
  assign in_smp[5] = in_data.sample_5;
  assign in_smp[6] = in_data.sample_6;
  assign in_smp[7] = in_data.sample_7;

  assign trig_smp = in_smp[trig_sel_r];

  always_comb begin
    case (cmp_mode_r)
      CMP_UGT:    hit = trig_smp > thresh_r;
      CMP_ULT:    hit = trig_smp < thresh_r;
      CMP_SGT:    hit = $signed(trig_smp) > $signed(thresh_r);
      CMP_SLT:    hit = $signed(trig_smp) < $signed(thresh_r);
      CMP_EQ:     hit = trig_smp == thresh_r;
      CMP_NE:     hit = trig_smp != thresh_r;
      CMP_ALWAYS: hit = 1'b1;
      default:    hit = 1'b0;
    endcase
  end

  // channel count saturates at the channel limit
  assign n_sat = (chan_cnt_r > 4'(CHAN_LIMIT)) ? CNT_W'(CHAN_LIMIT)
                                               : chan_cnt_r[CNT_W-1:0];

  // handshake between the stages
  assign emt_last = !emt_cap_r || ((CNT_W'(beat_r) + CNT_W'(1)) == emt_n_r);
  assign emt_done = emt_valid_r && !out_stall && emt_last;
  assign emt_load = stg_valid_r && (!emt_valid_r || emt_done);
  assign in_stall = stg_valid_r && !emt_load;
  assign in_acc   = in_valid && !in_stall;

  // flag and count update for one request
  always_comb begin
    flags_nxt   = flags_r;
    tick_nxt    = tick_r;
    stg_cap_nxt = 1'b0;
    if (in_data.opcode == OP_CONTROL) begin
      flags_nxt.armed  = in_data.control_flags[0];
      flags_nxt.active = in_data.control_flags[1];
      flags_nxt.done   = in_data.control_flags[2];
    end else begin
      if (flags_r.armed) begin
        if (hit) flags_nxt.active = 1'b1;
        if (flags_nxt.active) begin
          flags_nxt.armed = 1'b0;
          tick_nxt        = '0;
        end
      end
      if (flags_nxt.active || cont_r) begin
        tick_nxt = tick_nxt + 32'd1;
        if (tick_nxt == total_r) begin
          flags_nxt.done   = 1'b1;
          flags_nxt.active = 1'b0;
        end
        stg_cap_nxt = (n_sat != '0);
      end
    end
  end

  assign stg_n_nxt = n_sat;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_acc)        stg_valid_nxt = 1'b1;
    else if (emt_load) stg_valid_nxt = 1'b0;

    emt_valid_nxt = emt_valid_r;
    beat_nxt      = beat_r;
    if (emt_load) begin
      emt_valid_nxt = 1'b1;
      beat_nxt      = '0;
    end else if (emt_done) begin
      emt_valid_nxt = 1'b0;
    end else if (emt_valid_r && !out_stall) begin
      beat_nxt = beat_r + IDX_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      tick_r      <= '0;
      stg_valid_r <= 1'b0;
      emt_valid_r <= 1'b0;
      beat_r      <= '0;
    end else begin
      if (in_acc) begin
        flags_r <= flags_nxt;
        tick_r  <= tick_nxt;
      end
      stg_valid_r <= stg_valid_nxt;
      emt_valid_r <= emt_valid_nxt;
      beat_r      <= beat_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_cap_r   <= stg_cap_nxt;
      stg_n_r     <= stg_n_nxt;
      stg_flags_r <= flags_nxt;
      for (int i = 0; i < CHAN_LIMIT; i++) stg_smp_r[i] <= in_smp[i];
    end
    if (emt_load) begin
      emt_cap_r   <= stg_cap_r;
      emt_n_r     <= stg_n_r;
      emt_flags_r <= stg_flags_r;
      for (int i = 0; i < CHAN_LIMIT; i++) emt_smp_r[i] <= stg_smp_r[i];
    end
  end

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  assign out_valid = emt_valid_r;

  always_comb begin
    out_data                  = '0;
    out_data.last             = emt_last;
    out_data.armed_flag       = emt_flags_r.armed;
    out_data.active_flag      = emt_flags_r.active;
    out_data.done_flag        = emt_flags_r.done;
    if (emt_cap_r) begin
      out_data.has_sample       = 1'b1;
      out_data.channel_index    = 3'(beat_r);
      out_data.register_address = addr_tbl_r[8*int'(beat_r) +: 8];
      out_data.sample_value     = emt_smp_r[beat_r];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_beat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (emt_valid_r && emt_cap_r) |-> ((CNT_W'(beat_r) + CNT_W'(1)) <= emt_n_r))
    else $error("beat counter past channel count");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && !emt_valid_r) |=> emt_valid_r)
    else $error("staged result set not moved to output stage");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_sample) |-> out_data.last)
    else $error("status result not marked last");

  a_beat_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last) |=>
      (out_valid && (beat_r == $past(beat_r) + IDX_W'(1))))
    else $error("result beat did not advance");

endmodule
